// ----- rtl/pct_pkg.sv -----
package pct_pkg;

    // table geometry
    localparam int MAX_POSITIONS = 256;
    localparam int MIN_TURN      = 3;
    localparam int POS_W         = 9;
    localparam int LOOP_W        = POS_W + 1;
    localparam int TABLE_DEPTH   = MAX_POSITIONS * (MAX_POSITIONS + 1) / 2;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CODE_W        = 3;
    localparam int KIND_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int PHASE_W       = 3;

    // stored codes
    localparam logic [CODE_W-1:0] CODE_FREE      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PAIR      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_BANNED    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SINGLE    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_MUST_PAIR = 3'd4;
    localparam logic [CODE_W-1:0] CODE_IN_BANNED = 3'd5;

    // item kinds
    localparam logic [KIND_W-1:0] K_FORCE_PAIR  = 4'd0;
    localparam logic [KIND_W-1:0] K_BAN_PAIR    = 4'd1;
    localparam logic [KIND_W-1:0] K_SINGLE      = 4'd2;
    localparam logic [KIND_W-1:0] K_UNKNOWN     = 4'd3;
    localparam logic [KIND_W-1:0] K_STACK       = 4'd4;
    localparam logic [KIND_W-1:0] K_HAIRPIN     = 4'd5;
    localparam logic [KIND_W-1:0] K_INTERNAL    = 4'd6;
    localparam logic [KIND_W-1:0] K_REGION      = 4'd7;
    localparam logic [KIND_W-1:0] K_PROBE       = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  first_pos;
        logic [POS_W-1:0]  second_pos;
        logic [POS_W-1:0]  inner_first;
        logic [POS_W-1:0]  inner_second;
    } t_in_item;

    typedef struct packed {
        logic              answer;
        logic [CODE_W-1:0] pair_code;
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] second_code;
    } t_out_item;

    typedef struct packed {
        logic             enabled;
        logic             limit;
        logic [POS_W-1:0] contact;
        logic [POS_W-1:0] len;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] wdata;
    } t_mem_req;

endpackage

// ----- rtl/pct_ram.sv -----
module pct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pct_engine.sv -----
module pct_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pct_pkg::t_cfg                     i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pct_pkg::t_in_item                 i_in_item,
    output logic                              o_res_valid,
    output pct_pkg::t_out_item                o_res,
    input  logic                              i_res_ready,
    output pct_pkg::t_mem_req                 o_mem,
    input  logic [pct_pkg::CODE_W-1:0]        i_mem_rdata
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_RUN   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic [pct_pkg::LOOP_W-1:0] a_lo;
        logic [pct_pkg::LOOP_W-1:0] a_hi;
        logic [pct_pkg::LOOP_W-1:0] b_lo;
        logic [pct_pkg::LOOP_W-1:0] b_hi;
        logic                       diag;
        logic                       wr;
        logic [pct_pkg::CODE_W-1:0] val;
    } t_desc;

    localparam logic [pct_pkg::PHASE_W-1:0] LAST_PHASE = '1;

    t_state                         r_state;
    pct_pkg::t_in_item              r_item;
    logic [pct_pkg::PHASE_W-1:0]    r_ph;
    logic                           r_init;
    logic [pct_pkg::LOOP_W-1:0]     r_a;
    logic [pct_pkg::LOOP_W-1:0]     r_b;
    logic [pct_pkg::ADDR_W-1:0]     r_clr;
    logic                           r_rd_vld;
    logic                           r_rd_ok;
    logic [pct_pkg::PHASE_W-1:0]    r_rd_ph;
    logic [pct_pkg::CODE_W-1:0]     r_pc, r_ci, r_cj, r_pc2, r_cp, r_cq;
    logic                           r_blk;

    t_desc                          d;
    logic                           d_skip;
    logic                           d_empty;
    logic [pct_pkg::LOOP_W-1:0]     vi, vj, vp, vq, vlen;
    logic [pct_pkg::LOOP_W-1:0]     op_b;
    logic                           op_issue;
    logic                           op_ok;
    logic [pct_pkg::CODE_W-1:0]     rd_val;
    logic                           is_write;
    logic                           wr_ok;
    logic [pct_pkg::POS_W-1:0]      sw_i, sw_j;

    function automatic logic [pct_pkg::LOOP_W-1:0] inc(input logic [pct_pkg::LOOP_W-1:0] x);
        inc = x + pct_pkg::LOOP_W'(1);
    endfunction

    function automatic logic [pct_pkg::LOOP_W-1:0] dec(input logic [pct_pkg::LOOP_W-1:0] x);
        dec = (x == '0) ? '0 : x - pct_pkg::LOOP_W'(1);
    endfunction

    // triangular address: hi*(hi-1)/2 + lo-1
    function automatic logic [pct_pkg::ADDR_W-1:0] tri_addr(
        input logic [pct_pkg::LOOP_W-1:0] x,
        input logic [pct_pkg::LOOP_W-1:0] y
    );
        logic [pct_pkg::POS_W-1:0]   lo, hi;
        logic [2*pct_pkg::POS_W-1:0] prod;
        lo = (x < y) ? x[pct_pkg::POS_W-1:0] : y[pct_pkg::POS_W-1:0];
        hi = (x < y) ? y[pct_pkg::POS_W-1:0] : x[pct_pkg::POS_W-1:0];
        prod = (2*pct_pkg::POS_W)'(hi) * (2*pct_pkg::POS_W)'(hi - pct_pkg::POS_W'(1));
        tri_addr = pct_pkg::ADDR_W'((prod >> 1) + (2*pct_pkg::POS_W)'(lo)
                   - (2*pct_pkg::POS_W)'(1));
    endfunction

    function automatic logic in_table(
        input logic [pct_pkg::LOOP_W-1:0] x,
        input logic [pct_pkg::LOOP_W-1:0] y
    );
        logic [pct_pkg::LOOP_W-1:0] lo, hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        in_table = (lo != '0) && (hi <= pct_pkg::LOOP_W'(pct_pkg::MAX_POSITIONS));
    endfunction

    function automatic logic within_cd(
        input logic                      lim,
        input logic [pct_pkg::POS_W-1:0] cd,
        input logic [pct_pkg::POS_W-1:0] x,
        input logic [pct_pkg::POS_W-1:0] y
    );
        logic signed [pct_pkg::POS_W+1:0] diff;
        diff = $signed({2'b00, y}) - $signed({2'b00, x});
        within_cd = !lim || (diff <= $signed({2'b00, cd}));
    endfunction

    function automatic logic stack_ok(
        input logic [pct_pkg::CODE_W-1:0] pc,
        input logic [pct_pkg::CODE_W-1:0] ci,
        input logic [pct_pkg::CODE_W-1:0] cj
    );
        stack_ok = !(pc == pct_pkg::CODE_BANNED || ci == pct_pkg::CODE_SINGLE
                     || cj == pct_pkg::CODE_SINGLE)
                   && !((ci == pct_pkg::CODE_MUST_PAIR || cj == pct_pkg::CODE_MUST_PAIR)
                        && pc != pct_pkg::CODE_PAIR);
    endfunction

    assign vi   = {1'b0, r_item.first_pos};
    assign vj   = {1'b0, r_item.second_pos};
    assign vp   = {1'b0, r_item.inner_first};
    assign vq   = {1'b0, r_item.inner_second};
    assign vlen = {1'b0, i_cfg.len};
    assign is_write = (r_item.kind == pct_pkg::K_FORCE_PAIR) || (r_item.kind == pct_pkg::K_BAN_PAIR)
                   || (r_item.kind == pct_pkg::K_SINGLE) || (r_item.kind == pct_pkg::K_UNKNOWN);

    // loop bounds of the current phase
    always_comb begin
        d      = '0;
        d_skip = 1'b0;
        d.wr   = is_write;
        case (r_item.kind)
            pct_pkg::K_FORCE_PAIR: begin
                case (r_ph)
                    3'd0: begin
                        d.a_lo = pct_pkg::LOOP_W'(1); d.a_hi = dec(vi);
                        d.b_lo = vi;                  d.b_hi = vj;
                        d.val  = pct_pkg::CODE_BANNED;
                    end
                    3'd1: begin
                        d.a_lo = vi;      d.a_hi = vj;
                        d.b_lo = inc(vj); d.b_hi = vlen;
                        d.val  = pct_pkg::CODE_BANNED;
                    end
                    3'd2: begin
                        d.a_lo = vi;      d.a_hi = vi;
                        d.b_lo = inc(vi); d.b_hi = dec(vj);
                        d.val  = pct_pkg::CODE_BANNED;
                    end
                    3'd3: begin
                        d.a_lo = inc(vi); d.a_hi = dec(vj);
                        d.b_lo = vj;      d.b_hi = vj;
                        d.val  = pct_pkg::CODE_BANNED;
                    end
                    3'd4: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vi; d.b_hi = vi;
                        d.val  = pct_pkg::CODE_MUST_PAIR;
                    end
                    3'd5: begin
                        d.a_lo = vj; d.a_hi = vj; d.b_lo = vj; d.b_hi = vj;
                        d.val  = pct_pkg::CODE_MUST_PAIR;
                    end
                    3'd6: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vj; d.b_hi = vj;
                        d.val  = pct_pkg::CODE_PAIR;
                    end
                    default: d_skip = 1'b1;
                endcase
            end
            pct_pkg::K_BAN_PAIR: begin
                case (r_ph)
                    3'd0: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vj; d.b_hi = vj;
                        d.val  = pct_pkg::CODE_BANNED;
                    end
                    3'd1: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vi; d.b_hi = vi;
                        d.val  = pct_pkg::CODE_IN_BANNED;
                    end
                    3'd2: begin
                        d.a_lo = vj; d.a_hi = vj; d.b_lo = vj; d.b_hi = vj;
                        d.val  = pct_pkg::CODE_IN_BANNED;
                    end
                    default: d_skip = 1'b1;
                endcase
            end
            pct_pkg::K_SINGLE, pct_pkg::K_UNKNOWN: begin
                case (r_ph)
                    3'd0: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vi; d.b_hi = vi;
                        d.val  = pct_pkg::CODE_SINGLE;
                    end
                    3'd1: begin
                        d.a_lo = vi;                  d.a_hi = vi;
                        d.b_lo = pct_pkg::LOOP_W'(1); d.b_hi = dec(vi);
                        d.val  = pct_pkg::CODE_BANNED;
                        d_skip = (r_item.kind == pct_pkg::K_UNKNOWN);
                    end
                    3'd2: begin
                        d.a_lo = vi;      d.a_hi = vi;
                        d.b_lo = inc(vi); d.b_hi = vlen;
                        d.val  = pct_pkg::CODE_BANNED;
                    end
                    default: d_skip = 1'b1;
                endcase
            end
            default: begin
                // queries: point reads, then diagonal scans
                case (r_ph)
                    3'd0: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vj; d.b_hi = vj;
                    end
                    3'd1: begin
                        d.a_lo = vi; d.a_hi = vi; d.b_lo = vi; d.b_hi = vi;
                    end
                    3'd2: begin
                        d.a_lo = vj; d.a_hi = vj; d.b_lo = vj; d.b_hi = vj;
                    end
                    3'd3: begin
                        d.a_lo = vp; d.a_hi = vp; d.b_lo = vq; d.b_hi = vq;
                        d_skip = (r_item.kind != pct_pkg::K_INTERNAL);
                    end
                    3'd4: begin
                        d.a_lo = vp; d.a_hi = vp; d.b_lo = vp; d.b_hi = vp;
                        d_skip = (r_item.kind != pct_pkg::K_INTERNAL);
                    end
                    3'd5: begin
                        d.a_lo = vq; d.a_hi = vq; d.b_lo = vq; d.b_hi = vq;
                        d_skip = (r_item.kind != pct_pkg::K_INTERNAL);
                    end
                    3'd6: begin
                        d.diag = 1'b1;
                        d.a_lo = inc(vi);
                        d.a_hi = (r_item.kind == pct_pkg::K_INTERNAL) ? dec(vp) : dec(vj);
                        d_skip = !i_cfg.enabled || !(r_item.kind == pct_pkg::K_HAIRPIN
                                 || r_item.kind == pct_pkg::K_INTERNAL
                                 || r_item.kind == pct_pkg::K_REGION);
                    end
                    default: begin
                        d.diag = 1'b1;
                        d.a_lo = inc(vq);
                        d.a_hi = dec(vj);
                        d_skip = !i_cfg.enabled || (r_item.kind != pct_pkg::K_INTERNAL);
                    end
                endcase
            end
        endcase
        d_empty = d_skip || (d.a_lo > d.a_hi) || (d.b_lo > d.b_hi);
    end

    // access of the current loop step
    assign op_b     = d.diag ? r_a : r_b;
    assign op_issue = (r_state == S_RUN) && !r_init;
    assign op_ok    = in_table(r_a, op_b);
    assign rd_val   = r_rd_ok ? i_mem_rdata : pct_pkg::CODE_FREE;

    // memory request: clearing pass, or table read or write
    always_comb begin
        o_mem = '0;
        if (r_state == S_CLEAR) begin
            o_mem.we    = 1'b1;
            o_mem.addr  = r_clr;
            o_mem.wdata = pct_pkg::CODE_FREE;
        end else begin
            o_mem.we    = op_issue && d.wr;
            o_mem.addr  = tri_addr(r_a, op_b);
            o_mem.wdata = d.val;
        end
    end

    // write ordering and range checks on the captured item
    always_comb begin
        sw_i  = (r_item.first_pos > r_item.second_pos) ? r_item.second_pos : r_item.first_pos;
        sw_j  = (r_item.first_pos > r_item.second_pos) ? r_item.first_pos : r_item.second_pos;
        wr_ok = 1'b0;
        case (r_item.kind)
            pct_pkg::K_FORCE_PAIR:
                wr_ok = (sw_i != '0) && (sw_j <= i_cfg.len)
                        && ((sw_j - sw_i) >= pct_pkg::POS_W'(pct_pkg::MIN_TURN))
                        && (sw_j != sw_i);
            pct_pkg::K_BAN_PAIR:
                wr_ok = (sw_i != '0) && (sw_j <= i_cfg.len);
            pct_pkg::K_SINGLE, pct_pkg::K_UNKNOWN:
                wr_ok = (r_item.first_pos != '0) && (r_item.first_pos <= i_cfg.len);
            default: wr_ok = 1'b0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_rd_vld <= 1'b0;
            r_ph     <= '0;
            r_init   <= 1'b1;
        end else begin
            r_rd_vld <= op_issue && !d.wr;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + pct_pkg::ADDR_W'(1);
                    if (r_clr == pct_pkg::ADDR_W'(pct_pkg::TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_ph   <= '0;
                    r_init <= 1'b1;
                    if (is_write) begin
                        r_state <= wr_ok ? S_RUN : S_IDLE;
                    end else if (r_item.kind <= pct_pkg::K_PROBE) begin
                        r_state <= S_RUN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RUN: begin
                    if (r_init) begin
                        if (d_empty) begin
                            r_ph <= r_ph + pct_pkg::PHASE_W'(1);
                            if (r_ph == LAST_PHASE) begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_a    <= d.a_lo;
                            r_b    <= d.b_lo;
                            r_init <= 1'b0;
                        end
                    end else if (r_b == d.b_hi || d.diag) begin
                        if (r_a == d.a_hi) begin
                            r_init <= 1'b1;
                            r_ph   <= r_ph + pct_pkg::PHASE_W'(1);
                            if (r_ph == LAST_PHASE) begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_a <= inc(r_a);
                            r_b <= d.b_lo;
                        end
                    end else begin
                        r_b <= inc(r_b);
                    end
                end
                S_DRAIN: begin
                    r_state <= is_write ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item capture, read tracking and code collection
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (r_state == S_CHECK) begin
            r_blk <= 1'b0;
            // only pair writes are ordered smaller first
            if (r_item.kind == pct_pkg::K_FORCE_PAIR || r_item.kind == pct_pkg::K_BAN_PAIR) begin
                r_item.first_pos  <= sw_i;
                r_item.second_pos <= sw_j;
            end
        end
        r_rd_ok <= op_ok;
        r_rd_ph <= r_ph;
        if (r_rd_vld) begin
            case (r_rd_ph)
                3'd0: r_pc  <= rd_val;
                3'd1: r_ci  <= rd_val;
                3'd2: r_cj  <= rd_val;
                3'd3: r_pc2 <= rd_val;
                3'd4: r_cp  <= rd_val;
                3'd5: r_cq  <= rd_val;
                default: begin
                    if (rd_val == pct_pkg::CODE_MUST_PAIR) begin
                        r_blk <= 1'b1;
                    end
                end
            endcase
        end
    end

    // answer from collected codes
    always_comb begin
        logic wcd_ij, wcd_pq, st1, st2, reg_ok;
        wcd_ij = within_cd(i_cfg.limit, i_cfg.contact, r_item.first_pos, r_item.second_pos);
        wcd_pq = within_cd(i_cfg.limit, i_cfg.contact, r_item.inner_first, r_item.inner_second);
        st1    = (!i_cfg.enabled || stack_ok(r_pc, r_ci, r_cj)) && wcd_ij;
        st2    = (!i_cfg.enabled || stack_ok(r_pc2, r_cp, r_cq)) && wcd_pq;
        reg_ok = !i_cfg.enabled || !r_blk;
        o_res             = '0;
        o_res.pair_code   = r_pc;
        o_res.first_code  = r_ci;
        o_res.second_code = r_cj;
        case (r_item.kind)
            pct_pkg::K_STACK:    o_res.answer = st1;
            pct_pkg::K_HAIRPIN:  o_res.answer = i_cfg.enabled ? (st1 && reg_ok) : wcd_ij;
            pct_pkg::K_INTERNAL: o_res.answer = i_cfg.enabled ? (st1 && st2 && reg_ok)
                                                              : (wcd_ij && wcd_pq);
            pct_pkg::K_REGION:   o_res.answer = reg_ok;
            default:             o_res.answer = 1'b0;
        endcase
    end

    assign o_res_valid = (r_state == S_OUT);
    assign o_in_stall  = (r_state != S_IDLE);

endmodule

// ----- rtl/rna_pair_constraint_table.sv -----
// Pair-constraint table over sequence positions, one 3-bit code per position pair, held
// in a single-port synchronous RAM that is touched one entry per cycle. After reset a
// clearing pass writes every one of the 32896 entries while input is stalled;
// configuration writes are taken at any time. Items are handled one at a time. A prohibit
// is 3 entries, force single/unknown up to sequence_length entries, a force pair touches
// every entry it bans (up to about 16K at full length). Queries read 3 codes (6 for an
// internal loop) plus one diagonal code per position of the scanned regions.
module rna_pair_constraint_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pct_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pct_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pct_pkg::POS_W-1:0]         i_cfg_data
);

    logic                       r_enabled;
    logic                       r_limit;
    logic [pct_pkg::POS_W-1:0]  r_contact;
    logic [pct_pkg::POS_W-1:0]  r_seq_len;
    logic                       r_out_valid;
    pct_pkg::t_out_item         r_out_data;

    pct_pkg::t_cfg              cfg;
    pct_pkg::t_mem_req          mem_req;
    logic [pct_pkg::CODE_W-1:0] mem_rdata;
    logic                       res_valid;
    logic                       res_ready;
    pct_pkg::t_out_item         res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_limit   <= 1'b0;
            r_contact <= '0;
            r_seq_len <= pct_pkg::POS_W'(pct_pkg::MAX_POSITIONS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pct_pkg::CFG_ENABLE:  r_enabled <= i_cfg_data[0];
                pct_pkg::CFG_LIMIT:   r_limit   <= i_cfg_data[0];
                pct_pkg::CFG_CONTACT: r_contact <= i_cfg_data;
                pct_pkg::CFG_SEQ_LEN: r_seq_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate the sequence length into the table
    always_comb begin
        cfg.enabled = r_enabled;
        cfg.limit   = r_limit;
        cfg.contact = r_contact;
        if (r_seq_len == '0) begin
            cfg.len = pct_pkg::POS_W'(1);
        end else if (r_seq_len > pct_pkg::POS_W'(pct_pkg::MAX_POSITIONS)) begin
            cfg.len = pct_pkg::POS_W'(pct_pkg::MAX_POSITIONS);
        end else begin
            cfg.len = r_seq_len;
        end
    end

    assign o_cfg_ready = 1'b1;

    pct_ram #(
        .WIDTH (pct_pkg::CODE_W),
        .DEPTH (pct_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    pct_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // output register, frees the engine once the beat is held here
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/pct_checker.sv -----
module pct_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  pct_pkg::t_out_item                o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while busy");

    // no result can appear the cycle after an accept
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result without table access");

endmodule

bind rna_pair_constraint_table pct_checker u_checker (.*);
